// ===== rtl/core/esc_pkg.sv =====
`default_nettype none
package esc_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP = 3'd0,
    REG_PA   = 3'd1,
    REG_PB   = 3'd2,
    REG_PC   = 3'd3,
    REG_HA   = 3'd4,
    REG_HB   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_TEMP  = 2'd0,
    FUNC_PRESS = 2'd1,
    FUNC_HUM   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // multiplier operand select
  typedef enum logic [4:0] {
    MOP_IDLE,
    // temperature
    MOP_T_A,    // (adc>>3 - t1<<1) * t2
    MOP_T_B,    // d*d
    MOP_T_C,    // (dd>>12)*t3
    // pressure
    MOP_P_VV,   // v1*v1
    MOP_P_VVP6, // vv*p6
    MOP_P_VP5,  // v1*p5
    MOP_P_VVP3, // vv*p3
    MOP_P_VP2,  // v1*p2
    MOP_P_P1,   // (2^47+v1)*p1
    MOP_P_NUM,  // (..)*3125
    MOP_P_P9A,  // p9*(p>>13)
    MOP_P_P9B,  // * (p>>13)
    MOP_P_P8,   // p8*p
    // humidity
    MOP_H_H5,   // h5*v
    MOP_H_H6,   // v*h6
    MOP_H_H3,   // v*h3
    MOP_H_B,    // x*y
    MOP_H_H2,   // (..)*h2
    MOP_H_AB,   // a*b
    MOP_H_SS,   // s*s
    MOP_H_H1    // (..)*h1
  } mop_t;

  typedef struct packed {
    mop_t mop;         // multiply step to run (result lands in work regs)
    logic div_start;   // start 64-bit divide
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_zero;    // pressure divisor is zero
  } dp_stat_t;

  function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
    asr64 = 64'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
    asr32 = 32'($signed(x) >>> n);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/env_sensor_compensation.sv =====
`default_nettype none
// Integer compensation of a combined temperature / pressure / humidity sensor.
// One request (func, raw_value) yields one value: 0.01 C, Pa, or 1/1024 %RH.
// Temperature requests update the stored fine-temperature term used by
// later pressure and humidity requests. Trim coefficients must be written
// through cfg_we/cfg_idx/cfg_data only while idle; the block itself does not
// enforce this. One request at a time: a shared 64-bit multiplier (three
// 32x32 partial products) is stepped by a controller, and pressure also uses
// a radix-2 divider. A result waits in out_valid until taken; no new request
// is accepted while it waits.
module env_sensor_compensation (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [esc_pkg::CfgIdxW-1:0]     cfg_idx,
  input  wire logic [esc_pkg::CfgDataW-1:0]    cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      func,
  input  wire logic [19:0]                     raw_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [31:0]                   value
);
  esc_pkg::dp_cmd_t  cmd;
  esc_pkg::dp_stat_t stat;
  logic load, mul_done, capture;
  logic [31:0] result;

  esc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .func_in(func),
    .in_ready(in_ready), .load(load), .cmd(cmd), .stat(stat),
    .mul_done(mul_done), .out_valid(out_valid), .out_ready(out_ready),
    .capture(capture)
  );

  esc_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .load(load), .func_in(func), .raw_in(raw_value),
    .cmd(cmd), .stat(stat), .mul_done(mul_done), .result(result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (capture) value <= $signed(result);
  end
endmodule
`default_nettype wire

// ===== rtl/core/esc_mul.sv =====
`default_nettype none
// 64x64 wrapping multiply, built from 32x32 partial products computed in turn.
module esc_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      prod
);
  logic [2:0]  step;
  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] pp;
  logic [31:0] xa;
  logic [31:0] xb;

  always_comb begin
    xa = ra[31:0];
    xb = rb[31:0];
    case (step)
      3'd1: begin xa = ra[31:0];  xb = rb[31:0];  end
      3'd2: begin xa = ra[63:32]; xb = rb[31:0];  end
      3'd3: begin xa = ra[31:0];  xb = rb[63:32]; end
      default: begin xa = ra[31:0]; xb = rb[31:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    pp <= 64'(xa) * 64'(xb);
    if (rst) begin
      step <= 3'd0;
      done <= 1'b0;
    end else if (start) begin
      ra <= a;
      rb <= b;
      step <= 3'd1;
      done <= 1'b0;
    end else begin
      done <= (step == 3'd4);
      case (step)
        3'd0: ;
        3'd2: begin prod <= pp; step <= 3'd3; end
        3'd3: begin prod[63:32] <= prod[63:32] + pp[31:0]; step <= 3'd4; end
        3'd4: begin
          prod[63:32] <= prod[63:32] + pp[31:0];
          step <= 3'd0;
        end
        default: step <= step + 3'd1;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/esc_div.sv =====
`default_nettype none
// Signed 64-bit truncating divide, one quotient bit per cycle.
module esc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             busy,
  output logic [63:0]      quot
);
  logic [6:0]  cnt;
  logic [63:0] q;
  logic [63:0] r;
  logic [63:0] d;
  logic        neg;
  logic [64:0] trial;

  assign trial = {r, q[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 7'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      q <= num[63] ? 64'd0 - num : num;
      d <= den[63] ? 64'd0 - den : den;
      r <= 64'd0;
      neg <= num[63] ^ den[63];
    end else if (busy) begin
      if (cnt == 7'd0) begin
        busy <= 1'b0;
        quot <= neg ? 64'd0 - q : q;
      end else begin
        cnt <= cnt - 7'd1;
        if (!trial[64]) begin
          r <= trial[63:0];
          q <= {q[62:0], 1'b1};
        end else begin
          r <= {r[62:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/esc_dp.sv =====
`default_nettype none
module esc_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [esc_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire logic [esc_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                   load,
  input  wire logic [1:0]             func_in,
  input  wire logic [19:0]            raw_in,
  input  wire esc_pkg::dp_cmd_t       cmd,
  output esc_pkg::dp_stat_t           stat,
  output logic                        mul_done,
  output logic [31:0]                 result
);
  logic [47:0] r_t, r_pa, r_pb, r_pc;
  logic [31:0] r_ha;
  logic [39:0] r_hb;
  logic [31:0] fine_temperature;
  logic [1:0]  func;
  logic [19:0] adc;
  // work registers
  logic [63:0] v1, vv, w2, w3, pp;
  logic [63:0] ma, mb, prod;
  logic        mstart;
  logic        div_busy;
  logic [63:0] quot;
  logic        div_zero;

  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;

  always_comb begin
    t1 = 32'(r_t[15:0]);
    t2 = 32'($signed(r_t[31:16]));
    t3 = 32'($signed(r_t[47:32]));
    p1 = 64'(r_pa[15:0]);
    p2 = 64'($signed(r_pa[31:16]));
    p3 = 64'($signed(r_pa[47:32]));
    p4 = 64'($signed(r_pb[15:0]));
    p5 = 64'($signed(r_pb[31:16]));
    p6 = 64'($signed(r_pb[47:32]));
    p7 = 64'($signed(r_pc[15:0]));
    p8 = 64'($signed(r_pc[31:16]));
    p9 = 64'($signed(r_pc[47:32]));
    h1 = 32'(r_ha[7:0]);
    h2 = 32'($signed(r_ha[23:8]));
    h3 = 32'(r_ha[31:24]);
    h4 = 32'($signed(r_hb[15:0]));
    h5 = 32'($signed(r_hb[31:16]));
    h6 = 32'($signed(r_hb[39:32]));
  end

  logic [31:0] adc32;
  assign adc32 = (func == esc_pkg::FUNC_HUM) ? 32'(adc[15:0]) : 32'(adc);

  // operand selection for the shared multiplier
  always_comb begin
    ma = 64'd0;
    mb = 64'd0;
    case (cmd.mop)
      esc_pkg::MOP_T_A:    begin ma = 64'((adc32 >> 3) - (t1 << 1)); mb = 64'(t2); end
      esc_pkg::MOP_T_B:    begin ma = 64'((adc32 >> 4) - t1); mb = ma; end
      esc_pkg::MOP_T_C:    begin ma = 64'(esc_pkg::asr32(w2[31:0], 12)); mb = 64'(t3); end
      esc_pkg::MOP_P_VV:   begin ma = v1; mb = v1; end
      esc_pkg::MOP_P_VVP6: begin ma = vv; mb = p6; end
      esc_pkg::MOP_P_VP5:  begin ma = v1; mb = p5; end
      esc_pkg::MOP_P_VVP3: begin ma = vv; mb = p3; end
      esc_pkg::MOP_P_VP2:  begin ma = v1; mb = p2; end
      esc_pkg::MOP_P_P1:   begin ma = (64'd1 << 47) + w3; mb = p1; end
      esc_pkg::MOP_P_NUM:  begin ma = pp; mb = 64'd3125; end
      esc_pkg::MOP_P_P9A:  begin ma = p9; mb = esc_pkg::asr64(quot, 13); end
      esc_pkg::MOP_P_P9B:  begin ma = w3; mb = esc_pkg::asr64(quot, 13); end
      esc_pkg::MOP_P_P8:   begin ma = p8; mb = quot; end
      esc_pkg::MOP_H_H5:   begin ma = 64'(h5); mb = 64'(v1[31:0]); end
      esc_pkg::MOP_H_H6:   begin ma = 64'(v1[31:0]); mb = 64'(h6); end
      esc_pkg::MOP_H_H3:   begin ma = 64'(v1[31:0]); mb = 64'(h3); end
      esc_pkg::MOP_H_B:    begin
        ma = 64'(esc_pkg::asr32(vv[31:0], 10));
        mb = 64'(esc_pkg::asr32(w2[31:0], 11) + 32'd32768);
      end
      esc_pkg::MOP_H_H2:   begin
        ma = 64'(esc_pkg::asr32(w2[31:0], 10) + 32'd2097152); mb = 64'(h2);
      end
      esc_pkg::MOP_H_AB:   begin ma = 64'(w3[31:0]); mb = 64'(w2[31:0]); end
      esc_pkg::MOP_H_SS:   begin
        ma = 64'(esc_pkg::asr32(vv[31:0], 15)); mb = ma;
      end
      esc_pkg::MOP_H_H1:   begin ma = 64'(esc_pkg::asr32(w2[31:0], 7)); mb = 64'(h1); end
      default: ;
    endcase
  end

  logic mul_busy;
  esc_pkg::mop_t mop_r;
  assign mstart = (cmd.mop != esc_pkg::MOP_IDLE) && !mul_busy;

  esc_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb),
    .done(mul_done), .prod(prod)
  );

  always_ff @(posedge clk) begin
    if (rst) mul_busy <= 1'b0;
    else if (mstart) mul_busy <= 1'b1;
    else if (mul_done) mul_busy <= 1'b0;
    if (mstart) mop_r <= cmd.mop;
  end

  esc_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(pp), .den(w3),
    .busy(div_busy), .quot(quot)
  );
  assign stat.div_busy = div_busy || cmd.div_start;
  assign stat.div_zero = div_zero;

  logic [31:0] hv, hq;
  logic [63:0] pfin;
  always_comb begin
    hv = w3[31:0] - esc_pkg::asr32(w2[31:0], 4);
    if (hv[31]) hv = 32'd0;
    if (hv > 32'd419430400) hv = 32'd419430400;
    hq = hv >> 12;
    pfin = esc_pkg::asr64(quot + w3 + w2, 8) + (p7 << 4);
    pfin = pfin[63] ? 64'd0 - ((64'd0 - pfin) >> 8) : pfin >> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_t <= '0; r_pa <= '0; r_pb <= '0; r_pc <= '0; r_ha <= '0; r_hb <= '0;
      fine_temperature <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          esc_pkg::REG_TEMP: r_t <= cfg_data;
          esc_pkg::REG_PA:   r_pa <= cfg_data;
          esc_pkg::REG_PB:   r_pb <= cfg_data;
          esc_pkg::REG_PC:   r_pc <= cfg_data;
          esc_pkg::REG_HA:   r_ha <= cfg_data[31:0];
          esc_pkg::REG_HB:   r_hb <= cfg_data[39:0];
          default: ;
        endcase
      end
      if (load) begin
        func <= func_in;
        adc <= raw_in;
        if (func_in == esc_pkg::FUNC_HUM) v1 <= 64'(fine_temperature - 32'd76800);
        else v1 <= 64'($signed(fine_temperature)) - 64'd128000;
        w2 <= 64'd0; w3 <= 64'd0; vv <= 64'd0; pp <= 64'd0;
        div_zero <= 1'b0;
      end
      if (mul_done) begin
        case (mop_r)
          esc_pkg::MOP_T_A:    w3 <= 64'(esc_pkg::asr32(prod[31:0], 11));
          esc_pkg::MOP_T_B:    w2 <= prod;
          esc_pkg::MOP_T_C:    fine_temperature <= w3[31:0] +
                                 esc_pkg::asr32(prod[31:0], 14);
          esc_pkg::MOP_P_VV:   vv <= prod;
          esc_pkg::MOP_P_VVP6: w2 <= prod;
          esc_pkg::MOP_P_VP5:  w2 <= w2 + (prod << 17) + (p4 << 35);
          esc_pkg::MOP_P_VVP3: w3 <= esc_pkg::asr64(prod, 8);
          esc_pkg::MOP_P_VP2:  begin
            w3 <= w3 + (prod << 12);
            pp <= (64'd1048576 - 64'(adc)) << 31;
          end
          esc_pkg::MOP_P_P1:   begin
            w3 <= esc_pkg::asr64(prod, 33);
            div_zero <= (esc_pkg::asr64(prod, 33) == 64'd0);
          end
          esc_pkg::MOP_P_NUM:  pp <= prod;
          esc_pkg::MOP_P_P9A:  w3 <= prod;
          esc_pkg::MOP_P_P9B:  w3 <= esc_pkg::asr64(prod, 25);
          esc_pkg::MOP_P_P8:   w2 <= esc_pkg::asr64(prod, 19);
          esc_pkg::MOP_H_H5:
            w3 <= 64'(esc_pkg::asr32((adc32 << 14) - (h4 << 20) - prod[31:0]
                 + 32'd16384, 15));
          esc_pkg::MOP_H_H6:   vv <= prod;
          esc_pkg::MOP_H_H3:   w2 <= prod;
          esc_pkg::MOP_H_B:    w2 <= prod;
          esc_pkg::MOP_H_H2:   w2 <= 64'(esc_pkg::asr32(prod[31:0] + 32'd8192, 14));
          esc_pkg::MOP_H_AB:   begin w3 <= prod; vv <= prod; end
          esc_pkg::MOP_H_SS:   w2 <= prod;
          esc_pkg::MOP_H_H1:   w2 <= prod;
          default: ;
        endcase
      end
      // numerator for the divide: (p<<31 - v2)*3125 handled via MOP_P_NUM
      if (mul_done && mop_r == esc_pkg::MOP_P_P1) pp <= pp - w2;
    end
  end

  always_comb begin
    case (func)
      esc_pkg::FUNC_TEMP:  result = esc_pkg::asr32(fine_temperature * 32'd5 + 32'd128, 8);
      esc_pkg::FUNC_PRESS: result = div_zero ? 32'd0 : pfin[31:0];
      esc_pkg::FUNC_HUM:   result = hq;
      default:             result = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/esc_ctrl.sv =====
`default_nettype none
module esc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        func_in,
  output logic                   in_ready,
  output logic                   load,
  output esc_pkg::dp_cmd_t       cmd,
  input  wire esc_pkg::dp_stat_t stat,
  input  wire logic              mul_done,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   capture
);
  typedef enum logic [1:0] { S_IDLE, S_RUN, S_DIV, S_FIN } state_t;
  state_t state;
  logic [4:0] pc;
  logic [1:0] func;
  logic       waiting;
  logic       skip_div;

  localparam int TLen = 3;
  localparam int PLen1 = 6;
  localparam int PLen2 = 4;
  localparam int HLen = 8;

  esc_pkg::mop_t seq_op;
  always_comb begin
    seq_op = esc_pkg::MOP_IDLE;
    case (func)
      esc_pkg::FUNC_TEMP: begin
        case (pc)
          5'd0: seq_op = esc_pkg::MOP_T_A;
          5'd1: seq_op = esc_pkg::MOP_T_B;
          5'd2: seq_op = esc_pkg::MOP_T_C;
          default: ;
        endcase
      end
      esc_pkg::FUNC_PRESS: begin
        case (pc)
          5'd0: seq_op = esc_pkg::MOP_P_VV;
          5'd1: seq_op = esc_pkg::MOP_P_VVP6;
          5'd2: seq_op = esc_pkg::MOP_P_VP5;
          5'd3: seq_op = esc_pkg::MOP_P_VVP3;
          5'd4: seq_op = esc_pkg::MOP_P_VP2;
          5'd5: seq_op = esc_pkg::MOP_P_P1;
          5'd6: seq_op = esc_pkg::MOP_P_NUM;
          5'd7: seq_op = esc_pkg::MOP_P_P9A;
          5'd8: seq_op = esc_pkg::MOP_P_P9B;
          5'd9: seq_op = esc_pkg::MOP_P_P8;
          default: ;
        endcase
      end
      esc_pkg::FUNC_HUM: begin
        case (pc)
          5'd0: seq_op = esc_pkg::MOP_H_H5;
          5'd1: seq_op = esc_pkg::MOP_H_H6;
          5'd2: seq_op = esc_pkg::MOP_H_H3;
          5'd3: seq_op = esc_pkg::MOP_H_B;
          5'd4: seq_op = esc_pkg::MOP_H_H2;
          5'd5: seq_op = esc_pkg::MOP_H_AB;
          5'd6: seq_op = esc_pkg::MOP_H_SS;
          5'd7: seq_op = esc_pkg::MOP_H_H1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  logic [4:0] last;
  always_comb begin
    case (func)
      esc_pkg::FUNC_TEMP:  last = 5'(TLen);
      esc_pkg::FUNC_PRESS: last = 5'(PLen1 + PLen2);
      esc_pkg::FUNC_HUM:   last = 5'(HLen);
      default:             last = 5'd0;
    endcase
  end

  // divisor known after the first pressure phase; zero ends the request early
  assign skip_div = (func == esc_pkg::FUNC_PRESS) && (pc == 5'(PLen1)) && stat.div_zero;

  assign in_ready = (state == S_IDLE) && !out_valid && !rst;
  assign load = in_valid && in_ready;
  assign capture = (state == S_FIN);

  always_comb begin
    cmd = '0;
    cmd.mop = (state == S_RUN && !waiting && pc != last && !skip_div) ?
              seq_op : esc_pkg::MOP_IDLE;
    cmd.div_start = (state == S_DIV) && !waiting;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pc <= 5'd0;
      waiting <= 1'b0;
      func <= 2'd0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (load) begin
          func <= func_in;
          pc <= 5'd0;
          waiting <= 1'b0;
          state <= S_RUN;
        end
        S_RUN: begin
          if (pc == last || (skip_div && !waiting)) state <= S_FIN;
          else if (!waiting) waiting <= 1'b1;
          else if (mul_done) begin
            waiting <= 1'b0;
            pc <= pc + 5'd1;
            if (func == esc_pkg::FUNC_PRESS && pc == 5'(PLen1)) state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!waiting) waiting <= 1'b1;
          else if (!stat.div_busy) begin
            waiting <= 1'b0;
            state <= S_RUN;
          end
        end
        S_FIN: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> out_valid) else $error("result not presented");
  a_load_run: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == S_RUN)) else $error("load did not start");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for env_sensor_compensation.
// Requests come from a queue of pending readings. Each accepted request runs
// through a local copy of the compensation math, and the result goes into a
// queue of expected values. The monitor checks every returned value against
// the oldest entry in that queue.
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [esc_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [esc_pkg::CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = esc_pkg::FUNC_TEMP;
  logic [19:0] raw_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] value;

  env_sensor_compensation DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .raw_value(raw_value),
    .out_valid(out_valid), .out_ready(out_ready), .value(value)
  );

  always #5 clk = ~clk;

  typedef struct {
    esc_pkg::func_t kind;
    logic [19:0] raw;
  } reading_t;

  reading_t pending[$];
  reading_t cur;
  logic [31:0] expected_values[$];
  logic [31:0] got_exp;
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  bit hold_off = 1'b0;

  // local copy of trim registers and fine-temperature state
  logic [47:0] trim_temp, trim_pa, trim_pb, trim_pc;
  logic [31:0] trim_ha;
  logic [39:0] trim_hb;
  logic [31:0] fine_t;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] sext16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  // truncating signed divide with 2^64 wrap (divisor nonzero)
  function automatic logic [63:0] sdiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic logic [31:0] comp_temperature(input logic [31:0] adc);
    logic [31:0] t1, t2, t3, v1, d, v2, x;
    t1 = {16'b0, trim_temp[15:0]};
    t2 = {{16{trim_temp[31]}}, trim_temp[31:16]};
    t3 = {{16{trim_temp[47]}}, trim_temp[47:32]};
    x = (adc >> 3) - (t1 << 1);
    v1 = sra32(x * t2, 11);
    d = (adc >> 4) - t1;
    x = sra32(d * d, 12);
    v2 = sra32(x * t3, 14);
    fine_t = v1 + v2;
    x = fine_t * 32'd5 + 32'd128;
    return sra32(x, 8);
  endfunction

  function automatic logic [31:0] comp_pressure(input logic [31:0] adc);
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, x, y;
    p1 = {48'b0, trim_pa[15:0]};
    p2 = sext16(trim_pa[31:16]);
    p3 = sext16(trim_pa[47:32]);
    p4 = sext16(trim_pb[15:0]);
    p5 = sext16(trim_pb[31:16]);
    p6 = sext16(trim_pb[47:32]);
    p7 = sext16(trim_pc[15:0]);
    p8 = sext16(trim_pc[31:16]);
    p9 = sext16(trim_pc[47:32]);
    v1 = {{32{fine_t[31]}}, fine_t} - 64'd128000;
    v2 = v1 * v1 * p6;
    x = v1 * p5;
    v2 = v2 + (x << 17);
    v2 = v2 + (p4 << 35);
    x = v1 * v1 * p3;
    y = v1 * p2;
    v1 = sra64(x, 8) + (y << 12);
    x = ((64'd1 << 47) + v1) * p1;
    v1 = sra64(x, 33);
    if (v1 == 64'd0) return 32'd0;   // zero divisor
    p = 64'd1048576 - {32'b0, adc};
    x = ((p << 31) - v2) * 64'd3125;
    p = sdiv64(x, v1);
    y = sra64(p, 13);
    x = p9 * y * y;
    v1 = sra64(x, 25);
    x = p8 * p;
    v2 = sra64(x, 19);
    x = p + v1 + v2;
    p = sra64(x, 8) + (p7 << 4);
    x = sdiv64(p, 64'd256);
    return x[31:0];
  endfunction

  function automatic logic [31:0] comp_humidity(input logic [31:0] adc);
    logic [31:0] h1, h2, h3, h4, h5, h6, v, a, b, s, x;
    h1 = {24'b0, trim_ha[7:0]};
    h2 = {{16{trim_ha[23]}}, trim_ha[23:8]};
    h3 = {24'b0, trim_ha[31:24]};
    h4 = {{16{trim_hb[15]}}, trim_hb[15:0]};
    h5 = {{16{trim_hb[31]}}, trim_hb[31:16]};
    h6 = {{24{trim_hb[39]}}, trim_hb[39:32]};
    v = fine_t - 32'd76800;
    x = (adc << 14) - (h4 << 20) - (h5 * v) + 32'd16384;
    a = sra32(x, 15);
    x = v * h6;
    b = v * h3;
    b = sra32(x, 10) * (sra32(b, 11) + 32'd32768);
    x = (sra32(b, 10) + 32'd2097152) * h2 + 32'd8192;
    b = sra32(x, 14);
    v = a * b;
    s = sra32(v, 15);
    x = sra32(s * s, 7);
    x = x * h1;
    v = v - sra32(x, 4);
    // clamp to 0..419430400
    if (v[31]) v = 32'd0;
    if (v > 32'd419430400) v = 32'd419430400;
    return v >> 12;
  endfunction

  function automatic logic [31:0] compensate(input logic [1:0] kind, input logic [19:0] raw);
    case (kind)
      esc_pkg::FUNC_TEMP: return comp_temperature({12'b0, raw});
      esc_pkg::FUNC_PRESS: return comp_pressure({12'b0, raw});
      esc_pkg::FUNC_HUM: return comp_humidity({16'b0, raw[15:0]});
      default: return 32'd0;   // unused selector, state untouched
    endcase
  endfunction

  task automatic report(input string msg, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, msg, got, want);
    mismatches++;
  endtask

  // driver: predicts on acceptance, then offers the next request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_values.push_back(compensate(func, raw_value));
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur = pending.pop_front();
          in_valid <= 1'b1;
          func <= cur.kind;
          raw_value <= cur.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // long receiver hold-off so the block stalls its input
  initial begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        report("unexpected result", value, 32'hx);
      end else begin
        got_exp = expected_values.pop_front();
        if (value !== got_exp) report("value", value, got_exp);
      end
    end
  end

  task automatic write_reg(input esc_pkg::reg_idx_t idx, input logic [47:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      esc_pkg::REG_TEMP: trim_temp = data;
      esc_pkg::REG_PA: trim_pa = data;
      esc_pkg::REG_PB: trim_pb = data;
      esc_pkg::REG_PC: trim_pc = data;
      esc_pkg::REG_HA: trim_ha = data[31:0];
      esc_pkg::REG_HB: trim_hb = data[39:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [47:0] t, pa, pb, pc, ha, hb);
    write_reg(esc_pkg::REG_TEMP, t);
    write_reg(esc_pkg::REG_PA, pa);
    write_reg(esc_pkg::REG_PB, pb);
    write_reg(esc_pkg::REG_PC, pc);
    write_reg(esc_pkg::REG_HA, ha);
    write_reg(esc_pkg::REG_HB, hb);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain: all requests answered, then let the datapath settle
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || in_valid || expected_values.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic push(input esc_pkg::func_t k, input logic [19:0] raw);
    reading_t r;
    r.kind = k;
    r.raw = raw;
    pending.push_back(r);
  endtask

  task automatic add_directed();
    push(esc_pkg::FUNC_PRESS, 20'h80000);    // fine temp still from before
    push(esc_pkg::FUNC_HUM, 20'h08000);
    push(esc_pkg::FUNC_TEMP, 20'h00000);
    push(esc_pkg::FUNC_PRESS, 20'h00000);
    push(esc_pkg::FUNC_HUM, 20'h00000);
    push(esc_pkg::FUNC_TEMP, 20'hFFFFF);
    push(esc_pkg::FUNC_PRESS, 20'hFFFFF);
    push(esc_pkg::FUNC_HUM, 20'h0FFFF);
    push(esc_pkg::FUNC_HUM, 20'hFFFFF);       // upper bits ignored
    push(esc_pkg::FUNC_HUM, 20'hF0000);
    push(esc_pkg::FUNC_NONE, 20'hFFFFF);
    push(esc_pkg::FUNC_NONE, 20'h00000);
    push(esc_pkg::FUNC_PRESS, 20'h55555);     // after unused selector, state unchanged
    push(esc_pkg::FUNC_TEMP, 20'h82000);      // typical reading
    push(esc_pkg::FUNC_PRESS, 20'h55E00);
    push(esc_pkg::FUNC_HUM, 20'h06E00);
    push(esc_pkg::FUNC_TEMP, 20'h7FFFF);
    push(esc_pkg::FUNC_HUM, 20'h0AAAA);
    push(esc_pkg::FUNC_PRESS, 20'hAAAAA);
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(3))
      0: return 20'($urandom);
      1: return 20'($urandom_range(20'h9FFFF, 20'h60000));
      2: return {4'b0, 16'($urandom)};
      default: return $urandom_range(1) ? 20'hFFFFF : 20'h00000;
    endcase
  endfunction

  // mostly temperature first, then some pressure/humidity; the rest noise
  task automatic add_random(input int n);
    int cnt;
    int k;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 85) begin
        push(esc_pkg::FUNC_TEMP, rand_raw());
        cnt++;
        k = $urandom_range(4, 1);
        repeat (k) begin
          push($urandom_range(1) ? esc_pkg::FUNC_PRESS : esc_pkg::FUNC_HUM, rand_raw());
          cnt++;
        end
      end else begin
        push(esc_pkg::func_t'($urandom_range(3)), rand_raw());
        cnt++;
      end
    end
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  initial begin
    trim_temp = '0; trim_pa = '0; trim_pb = '0; trim_pc = '0;
    trim_ha = '0; trim_hb = '0; fine_t = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      // idling: sender 25 / receiver 45, then swapped, then none
      send_idle = (ph < 2) ? 25 : (ph < 4) ? 45 : 0;
      recv_idle = (ph < 2) ? 45 : (ph < 4) ? 25 : 0;
      case (ph)
        0: ;  // reset values: zero coefficients, zero divisor case
        1: write_all({16'hFC18, 16'd26435, 16'd27504},
                     {16'd3024, 16'hD843, 16'd36477},
                     {16'hFFF9, 16'd140, 16'd2855},
                     {16'd6000, 16'hC6F8, 16'd15500},
                     {16'd0, 8'd0, 16'd362, 8'd75},
                     {8'd0, 8'd30, 16'd50, 16'd313});
        2: write_all('1, '1, '1, '1, '1, '1);
        3: write_all({16'h8000, 16'h7FFF, 16'hFFFF},
                     {16'h7FFF, 16'h8000, 16'hFFFF},
                     {16'h8000, 16'h7FFF, 16'h8000},
                     {16'h7FFF, 16'h8000, 16'h7FFF},
                     {16'd0, 8'hFF, 16'h8000, 8'hFF},
                     {8'd0, 8'h80, 16'h7FFF, 16'h8000});
        default: write_all(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
      endcase
      if (ph <= 1) add_directed();
      if (ph == 1) hold_req = 1'b1;
      add_random(ph == 0 ? 150 : 215);
      drain();
    end

    if (expected_values.size() != 0)
      report("missing results", expected_values.size(), 32'd0);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
